FILE: rtl/core/chr_pkg.sv
// chr_pkg: shared types, constants and the arctangent table of the compass heading block.
// No dependencies; used by chr_cell, chr_post and compass_heading_relative.

package chr_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;

	localparam int VEC_W  = 28;
	localparam int ANG_W  = 24;
	localparam int HEAD_W = 15;

	localparam logic signed [ANG_W-1:0] HALF_TURN_FINE = 24'sd2949120;
	localparam logic signed [ANG_W-1:0] FULL_TURN_FINE = 24'sd5898240;
	localparam logic [HEAD_W-1:0]       FULL_TURN_OUT  = 15'd23040;
	localparam logic [ANG_W-2:0]        ROUND_HALF     = 23'd128;

	typedef struct packed {
		logic signed [VEC_W-1:0] re;
		logic signed [VEC_W-1:0] im;
		logic signed [ANG_W-1:0] z;
		logic                    zero;
		logic                    op;
	} chr_vec_t;

	function automatic logic signed [ANG_W-1:0] atan_fine(input int unsigned idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0:  v = 24'sd737280;
			1:  v = 24'sd435242;
			2:  v = 24'sd229970;
			3:  v = 24'sd116736;
			4:  v = 24'sd58595;
			5:  v = 24'sd29326;
			6:  v = 24'sd14667;
			7:  v = 24'sd7334;
			8:  v = 24'sd3667;
			9:  v = 24'sd1833;
			10: v = 24'sd917;
			11: v = 24'sd458;
			12: v = 24'sd229;
			13: v = 24'sd115;
			14: v = 24'sd57;
			15: v = 24'sd29;
			16: v = 24'sd14;
			17: v = 24'sd7;
			18: v = 24'sd4;
			19: v = 24'sd2;
			20: v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/compass_heading_relative.sv
// compass_heading_relative: magnetometer heading by a chain of CORDIC cells, plus relative heading.
// Depends on chr_pkg, chr_cell and chr_post.
//
// channel  dir  fields
// s_axis   in   tdata: x_msb, x_lsb, y_msb, y_lsb; tuser: operation
// m_axis   out  tdata: raw_heading, relative_heading
//
// One item per cycle while m_axis_tready is high; registers: each CORDIC cell, then post s1, s2.
// Each cell and post stage holds its own valid bit; a stall on m_axis_tready fills empty stages
// before it reaches s_axis_tready.
// Reset clears the valid bits and the reference heading.

module compass_heading_relative #(
	parameter int CORDIC_STAGES = chr_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // x_msb, x_lsb, y_msb, y_lsb
	input  logic [0:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // raw_heading, relative_heading, zero pad
);

	localparam int NUM_CELLS = (CORDIC_STAGES > chr_pkg::TABLE_LEN) ?
		chr_pkg::TABLE_LEN : CORDIC_STAGES;

	logic signed [15:0] xs;
	logic signed [15:0] ys;
	chr_pkg::chr_vec_t  pre;

	chr_pkg::chr_vec_t cell_data  [NUM_CELLS+1];
	logic              cell_valid [NUM_CELLS+1];
	logic              cell_ready [NUM_CELLS+1];

	logic [chr_pkg::HEAD_W-1:0] raw_heading;
	logic [chr_pkg::HEAD_W-1:0] relative_heading;

	always_comb begin
		xs       = $signed({s_axis_tdata[7:0], s_axis_tdata[15:8]});
		ys       = $signed({s_axis_tdata[23:16], s_axis_tdata[31:24]});
		pre.re   = {{(chr_pkg::VEC_W-24){ys[15]}}, ys, 8'd0};
		pre.im   = {{(chr_pkg::VEC_W-24){xs[15]}}, xs, 8'd0};
		pre.z    = '0;
		pre.zero = (xs == 16'sd0) && (ys == 16'sd0);
		pre.op   = s_axis_tuser[0];
		if (ys[15]) begin
			pre.re = -pre.re;
			pre.im = -pre.im;
			pre.z  = chr_pkg::HALF_TURN_FINE;
		end
	end

	assign cell_data[0]  = pre;
	assign cell_valid[0] = s_axis_tvalid;
	assign s_axis_tready = cell_ready[0];

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		chr_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cell_valid[i]),
			.in_ready (cell_ready[i]),
			.in_data  (cell_data[i]),
			.out_valid(cell_valid[i+1]),
			.out_ready(cell_ready[i+1]),
			.out_data (cell_data[i+1])
		);
	end

	chr_post u_post (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (cell_valid[NUM_CELLS]),
		.in_ready        (cell_ready[NUM_CELLS]),
		.in_data         (cell_data[NUM_CELLS]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.raw_heading     (raw_heading),
		.relative_heading(relative_heading)
	);

	assign m_axis_tdata = {2'b00, relative_heading, raw_heading};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:0] < chr_pkg::FULL_TURN_OUT)
		else $error("raw heading out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[29:15] < chr_pkg::FULL_TURN_OUT)
		else $error("relative heading out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a held output item");

endmodule

FILE: rtl/core/chr_cell.sv
// chr_cell: one CORDIC vectoring micro-rotation with its own item register.
// Depends on chr_pkg for the vector struct and the arctangent table.

module chr_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  chr_pkg::chr_vec_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output chr_pkg::chr_vec_t out_data
);

	localparam logic signed [chr_pkg::ANG_W-1:0] ATAN_C = chr_pkg::atan_fine(IDX);

	logic              valid_q;
	chr_pkg::chr_vec_t data_q;
	chr_pkg::chr_vec_t next_data;
	logic signed [chr_pkg::VEC_W-1:0] dre;
	logic signed [chr_pkg::VEC_W-1:0] dim;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		dre       = in_data.im >>> IDX;
		dim       = in_data.re >>> IDX;
		next_data = in_data;
		if (!in_data.im[chr_pkg::VEC_W-1]) begin
			next_data.re = in_data.re + dre;
			next_data.im = in_data.im - dim;
			next_data.z  = in_data.z + ATAN_C;
		end else begin
			next_data.re = in_data.re - dre;
			next_data.im = in_data.im + dim;
			next_data.z  = in_data.z - ATAN_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

endmodule

FILE: rtl/core/chr_post.sv
// chr_post: angle wrap and rounding to 1/64 degree, then the reference register and relative heading.
// Depends on chr_pkg for the vector struct and turn constants.

module chr_post (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  chr_pkg::chr_vec_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [chr_pkg::HEAD_W-1:0] raw_heading,
	output logic [chr_pkg::HEAD_W-1:0] relative_heading
);

	logic                       valid_s1;
	logic [chr_pkg::HEAD_W-1:0] head_s1;
	logic                       op_s1;
	logic                       ready_s1;
	logic                       valid_s2;
	logic [chr_pkg::HEAD_W-1:0] raw_s2;
	logic [chr_pkg::HEAD_W-1:0] rel_s2;
	logic [chr_pkg::HEAD_W-1:0] ref_q;

	logic signed [chr_pkg::ANG_W-1:0] z_wrap;
	logic [chr_pkg::ANG_W-2:0]        z_round;
	logic [chr_pkg::HEAD_W-1:0]       head_c;
	logic [chr_pkg::HEAD_W:0]         diff;
	logic [chr_pkg::HEAD_W-1:0]       rel_c;

	assign ready_s1         = !valid_s2 || out_ready;
	assign in_ready         = !valid_s1 || ready_s1;
	assign out_valid        = valid_s2;
	assign raw_heading      = raw_s2;
	assign relative_heading = rel_s2;

	always_comb begin
		z_wrap  = in_data.z[chr_pkg::ANG_W-1] ? in_data.z + chr_pkg::FULL_TURN_FINE : in_data.z;
		z_round = z_wrap[chr_pkg::ANG_W-2:0] + chr_pkg::ROUND_HALF;
		head_c  = z_round[chr_pkg::ANG_W-2 -: chr_pkg::HEAD_W];
		if (in_data.zero || head_c == chr_pkg::FULL_TURN_OUT) begin
			head_c = '0;
		end
	end

	always_comb begin
		diff = {1'b0, ref_q} - {1'b0, head_s1};
		if (diff[chr_pkg::HEAD_W]) begin
			diff = diff + {1'b0, chr_pkg::FULL_TURN_OUT};
		end
		rel_c = op_s1 ? '0 : diff[chr_pkg::HEAD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ref_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
				if (valid_s1 && op_s1) begin
					ref_q <= head_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			head_s1 <= head_c;
			op_s1   <= in_data.op;
		end
		if (ready_s1 && valid_s1) begin
			raw_s2 <= head_s1;
			rel_s2 <= rel_c;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> head_s1 < chr_pkg::FULL_TURN_OUT)
		else $error("heading out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> ref_q < chr_pkg::FULL_TURN_OUT)
		else $error("reference out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ready_s1 && valid_s1 && op_s1) |=> (rel_s2 == '0 && ref_q == raw_s2))
		else $error("capture did not zero relative heading");

endmodule

FILE: tb/sv/compass_heading_relative_test.sv
// compass_heading_relative_test: self-checking bench for the CORDIC compass heading block.
// Predicts raw and relative heading per accepted item and checks each output item in order.
// Depends on chr_pkg and compass_heading_relative.

module compass_heading_relative_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  STAGES         = chr_pkg::CORDIC_STAGES_DEF;
	localparam int  HW             = chr_pkg::HEAD_W;
	localparam int  DRAIN_CYCLES   = 48;
	localparam int  WATCHDOG_LIMIT = 4000;
	localparam logic OP_MEASURE    = 1'b0;
	localparam logic OP_CAPTURE    = 1'b1;

	localparam longint HALF_FINE = 2949120;
	localparam longint FULL_FINE = 5898240;
	localparam longint FULL_OUT  = 23040;
	localparam longint ARCTAN_FINE [24] = '{
		737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7, 4, 2, 1, 0, 0, 0
	};

	typedef struct packed {
		logic [HW-1:0] raw;
		logic [HW-1:0] rel;
	} heading_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // x_msb, x_lsb, y_msb, y_lsb
	logic [0:0]  s_axis_tuser = '0;  // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // raw_heading, relative_heading, zero pad

	heading_pair_t  expected_headings [$];
	logic [HW-1:0]  reference_heading = '0;
	int             src_idle_pct = 0;
	int             sink_idle_pct = 0;
	int             errors = 0;
	int             items_sent = 0;
	int             items_checked = 0;
	int             captures = 0;
	int             stall_cycles = 0;

	compass_heading_relative #(.CORDIC_STAGES(STAGES)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [HW-1:0] compass_heading(input logic signed [15:0] xs,
			input logic signed [15:0] ys);
		longint re, im, z, h, dre, dim;
		int     i;
		if (xs == 0 && ys == 0) begin
			return '0;
		end
		re = longint'(ys) * 256;
		im = longint'(xs) * 256;
		z  = 0;
		if (re < 0) begin
			re = -re;
			im = -im;
			z  = HALF_FINE;
		end
		for (i = 0; i < STAGES && i < 24; i++) begin
			dre = im >>> i;
			dim = re >>> i;
			if (im >= 0) begin
				re = re + dre;
				im = im - dim;
				z  = z + ARCTAN_FINE[i];
			end else begin
				re = re - dre;
				im = im + dim;
				z  = z - ARCTAN_FINE[i];
			end
		end
		while (z < 0) z = z + FULL_FINE;
		while (z >= FULL_FINE) z = z - FULL_FINE;
		h = (z + 128) >>> 8;
		if (h >= FULL_OUT) h = h - FULL_OUT;
		return h[HW-1:0];
	endfunction

	function automatic heading_pair_t predict_headings(input logic signed [15:0] xs,
			input logic signed [15:0] ys, input logic op);
		heading_pair_t p;
		longint        rel;
		p.raw = compass_heading(xs, ys);
		if (op == OP_CAPTURE) begin
			reference_heading = p.raw;
		end
		rel = longint'(reference_heading) + FULL_OUT - longint'(p.raw);
		if (rel >= FULL_OUT) rel = rel - FULL_OUT;
		p.rel = rel[HW-1:0];
		return p;
	endfunction

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("mismatch at item %0d: %s expected %0d got %0d", items_checked, what,
			exp_v, got_v);
		errors++;
	endtask

	task automatic send_item(input logic signed [15:0] xs, input logic signed [15:0] ys,
			input logic op);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {ys[7:0], ys[15:8], xs[7:0], xs[15:8]};
		s_axis_tuser  = op;
		do @(posedge clk); while (!s_axis_tready);
		expected_headings.push_back(predict_headings(xs, ys, op));
		items_sent++;
		if (op == OP_CAPTURE) captures++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_headings.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		heading_pair_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_headings.size() == 0) begin
				report_mismatch("unexpected item, raw_heading", -1,
					int'(m_axis_tdata[HW-1:0]));
			end else begin
				e = expected_headings.pop_front();
				if (m_axis_tdata[HW-1:0] !== e.raw)
					report_mismatch("raw_heading", int'(e.raw),
						int'(m_axis_tdata[HW-1:0]));
				if (m_axis_tdata[2*HW-1:HW] !== e.rel)
					report_mismatch("relative_heading", int'(e.rel),
						int'(m_axis_tdata[2*HW-1:HW]));
			end
			items_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(16'sd0, 16'sd0, OP_MEASURE);
		send_item(16'sd0, 16'sd0, OP_CAPTURE);
		send_item(16'sd0, 16'sd100, OP_MEASURE);
		send_item(16'sd100, 16'sd0, OP_MEASURE);
		send_item(16'sd0, -16'sd100, OP_MEASURE);
		send_item(-16'sd100, 16'sd0, OP_MEASURE);
		send_item(16'sd32767, 16'sd32767, OP_MEASURE);
		send_item(-16'sd32768, -16'sd32768, OP_MEASURE);
		send_item(16'sd32767, -16'sd32768, OP_MEASURE);
		send_item(-16'sd32768, 16'sd32767, OP_MEASURE);
		send_item(-16'sd1, 16'sd32767, OP_MEASURE);
		send_item(16'sd1, -16'sd32768, OP_MEASURE);
		send_item(-16'sd1, -16'sd32768, OP_MEASURE);
		send_item(16'sd0, -16'sd32768, OP_CAPTURE);
		send_item(16'sd123, -16'sd4567, OP_MEASURE);
		send_item(-16'sd32768, 16'sd0, OP_MEASURE);
		send_item(16'sd32767, 16'sd0, OP_MEASURE);
		send_item(16'sd0, 16'sd32767, OP_MEASURE);
		send_item(16'sd0, -16'sd1, OP_MEASURE);
		send_item(-16'sd1, 16'sd0, OP_MEASURE);
		send_item(16'sd1, 16'sd1, OP_CAPTURE);
		send_item(-16'sd1, -16'sd1, OP_MEASURE);
		send_item(-16'sd32768, -16'sd1, OP_MEASURE);
		send_item(16'sd0, 16'sd0, OP_MEASURE);
	endtask

	task automatic test_random_uniform(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			send_item(16'($urandom), 16'($urandom),
				($urandom_range(7) == 0) ? OP_CAPTURE : OP_MEASURE);
		end
	endtask

	task automatic test_small_vectors(input int count);
		int n;
		logic signed [15:0] xs, ys;
		for (n = 0; n < count; n++) begin
			xs = 16'(int'($urandom_range(16)) - 8);
			ys = 16'(int'($urandom_range(16)) - 8);
			send_item(xs, ys, ($urandom_range(9) == 0) ? OP_CAPTURE : OP_MEASURE);
		end
	endtask

	task automatic test_capture_runs(input int count);
		int n;
		logic signed [15:0] xs, ys;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(1)) begin
				xs = 16'($urandom);
				ys = 16'($urandom);
			end else begin
				xs = 16'(int'($urandom_range(512)) - 256);
				ys = 16'(int'($urandom_range(512)) - 256);
			end
			send_item(xs, ys, ($urandom_range(3) == 0) ? OP_CAPTURE : OP_MEASURE);
		end
	endtask

	task automatic test_drain_pause();
		test_random_uniform(30);
		wait_drained();
		test_capture_runs(30);
		wait_drained();
		test_random_uniform(30);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct  = 22;
		sink_idle_pct = 58;
		test_directed();
		test_random_uniform(450);

		src_idle_pct  = 58;
		sink_idle_pct = 22;
		test_small_vectors(250);
		test_capture_runs(200);
		test_drain_pause();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_uniform(300);
		test_capture_runs(100);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_headings.size() != 0) begin
			$display("%0d expected items never arrived", expected_headings.size());
			errors++;
		end

		$display("covered %0d items (%0d reference captures), %0d outputs checked, %0d errors",
			items_sent, captures, items_checked, errors);
		$display("zero vector, axes, full-scale corners, wrap at 360 and idle/stall mixes");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/chr_pkg.sv
rtl/core/chr_cell.sv
rtl/core/chr_post.sv
rtl/core/compass_heading_relative.sv
tb/sv/compass_heading_relative_test.sv
